// File: rtl/core/ple_pkg.sv
`timescale 1ns / 1ps
// Package for the positional list engine: field widths, list capacity,
// command and status codes. No dependencies.
package ple_pkg;

    // List capacity and derived widths
    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Field widths of the command and result words
    localparam int VAL_W = 32;
    localparam int OP_W  = 3;
    localparam int POS_W = 5;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    // Width used to compare a position against the entry count
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic signed [VAL_W-1:0] value_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_INSERT     = 3'd1,
        OP_READ       = 3'd2,
        OP_WRITE      = 3'd3,
        OP_REMOVE     = 3'd4
    } opcode_t;

    typedef enum logic [ST_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_BAD_POS = 2'd2,
        ST_FULL    = 2'd3
    } status_t;

endpackage

// File: rtl/core/positional_list_engine_core.sv
`timescale 1ns / 1ps
// Positional list engine: bounded ordered list with push, insert, read,
// overwrite and remove by 1-based position. Uses ple_pkg.
//
// Path: a command word passes through the command register, then the result
// register, before its result word is valid. Throughput: one command word per
// cycle while the result word is not stalled; insert and remove shift all entries in parallel.
// Reset: entry count, command and result valid flags clear; entry storage
// is not reset and is only read after being written.
module positional_list_engine_core
(
    input  logic                       clk,
    input  logic                       rst_n,

    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [ple_pkg::OP_W-1:0]   opcode,
    input  logic signed [ple_pkg::VAL_W-1:0] item_value,
    input  logic [ple_pkg::POS_W-1:0]  position,

    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [ple_pkg::VAL_W-1:0] result_value,
    output logic [ple_pkg::ST_W-1:0]   status,
    output logic [ple_pkg::LEN_W-1:0]  length
);

    // Command register
    logic                            cmd_valid_reg;
    logic [ple_pkg::OP_W-1:0]        cmd_opcode_reg;
    ple_pkg::value_t                 cmd_value_reg;
    logic [ple_pkg::POS_W-1:0]       cmd_position_reg;

    // List state
    ple_pkg::value_t                 entries_reg [ple_pkg::CAPACITY];
    ple_pkg::value_t                 entries_next [ple_pkg::CAPACITY];
    logic [ple_pkg::CNT_W-1:0]       count_reg;
    logic [ple_pkg::CNT_W-1:0]       count_next;

    // Result register
    logic                            res_valid_reg;
    ple_pkg::value_t                 res_value_reg;
    ple_pkg::value_t                 res_value_next;
    ple_pkg::status_t                res_status_reg;
    ple_pkg::status_t                res_status_next;
    logic [ple_pkg::LEN_W-1:0]       res_length_reg;

    // Handshake control
    logic                            exec_fire;
    logic                            in_fire;

    // Decode helpers
    logic [ple_pkg::CMP_W-1:0]       pos_cmp;
    logic [ple_pkg::CMP_W-1:0]       cnt_cmp;
    logic                            list_empty;
    logic                            list_full;
    logic                            pos_bad;
    logic [ple_pkg::POS_W-1:0]       pos_minus_one;
    logic [ple_pkg::IDX_W-1:0]       exec_idx;
    logic                            do_open;
    logic                            do_close;
    logic                            do_write;
    ple_pkg::value_t                 entry_at_idx;

    // Execute when the result register is free or being drained
    assign exec_fire = cmd_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall  = cmd_valid_reg && !exec_fire;
    assign in_fire   = in_valid && !in_stall;

    // Check position against the current entry count
    assign pos_cmp       = ple_pkg::CMP_W'(cmd_position_reg);
    assign cnt_cmp       = ple_pkg::CMP_W'(count_reg);
    assign list_empty    = (count_reg == '0);
    assign list_full     = (count_reg == ple_pkg::CNT_W'(ple_pkg::CAPACITY));
    assign pos_bad       = (pos_cmp == '0) || (pos_cmp > cnt_cmp);
    assign pos_minus_one = cmd_position_reg - ple_pkg::POS_W'(1);
    assign entry_at_idx  = entries_reg[exec_idx];

    // Decode the command into shift and write actions plus a status
    always_comb
    begin
        do_open         = 1'b0;
        do_close        = 1'b0;
        do_write        = 1'b0;
        exec_idx        = ple_pkg::IDX_W'(pos_minus_one);
        res_value_next  = '0;
        res_status_next = ple_pkg::ST_OK;
        case (cmd_opcode_reg)
            ple_pkg::OP_PUSH_FRONT:
            begin
                exec_idx = '0;
                if (list_full)
                begin
                    res_status_next = ple_pkg::ST_FULL;
                end
                else
                begin
                    do_open = 1'b1;
                end
            end
            ple_pkg::OP_INSERT, ple_pkg::OP_READ, ple_pkg::OP_WRITE, ple_pkg::OP_REMOVE:
            begin
                if (list_empty)
                begin
                    res_status_next = ple_pkg::ST_EMPTY;
                end
                else if (pos_bad)
                begin
                    res_status_next = ple_pkg::ST_BAD_POS;
                end
                else if (cmd_opcode_reg == ple_pkg::OP_INSERT)
                begin
                    if (list_full)
                    begin
                        res_status_next = ple_pkg::ST_FULL;
                    end
                    else
                    begin
                        do_open = 1'b1;
                    end
                end
                else if (cmd_opcode_reg == ple_pkg::OP_READ)
                begin
                    res_value_next = entry_at_idx;
                end
                else if (cmd_opcode_reg == ple_pkg::OP_WRITE)
                begin
                    do_write = 1'b1;
                end
                else
                begin
                    res_value_next = entry_at_idx;
                    do_close       = 1'b1;
                end
            end
            default:
            begin
                res_status_next = ple_pkg::ST_OK;
            end
        endcase
    end

    // Shift entries up or down around the index, or overwrite one slot
    always_comb
    begin
        for (int k = 0; k < ple_pkg::CAPACITY; k++)
        begin
            entries_next[k] = entries_reg[k];
            if (do_open)
            begin
                if (ple_pkg::IDX_W'(k) == exec_idx)
                begin
                    entries_next[k] = cmd_value_reg;
                end
                else if ((ple_pkg::IDX_W'(k) > exec_idx) && (k > 0))
                begin
                    entries_next[k] = entries_reg[(k > 0) ? k - 1 : 0];
                end
            end
            else if (do_close)
            begin
                if ((ple_pkg::IDX_W'(k) >= exec_idx) && (k < ple_pkg::CAPACITY - 1))
                begin
                    entries_next[k] = entries_reg[(k < ple_pkg::CAPACITY - 1) ? k + 1 : k];
                end
            end
            else if (do_write)
            begin
                if (ple_pkg::IDX_W'(k) == exec_idx)
                begin
                    entries_next[k] = cmd_value_reg;
                end
            end
        end
    end

    // Advance the entry count
    always_comb
    begin
        count_next = count_reg;
        if (do_open)
        begin
            count_next = count_reg + ple_pkg::CNT_W'(1);
        end
        else if (do_close)
        begin
            count_next = count_reg - ple_pkg::CNT_W'(1);
        end
    end

    // Hold control state: command valid, count, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                cmd_valid_reg <= 1'b1;
            end
            else if (exec_fire)
            begin
                cmd_valid_reg <= 1'b0;
            end
            if (exec_fire)
            begin
                count_reg     <= count_next;
                res_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Capture command word, entries and result word
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_opcode_reg   <= opcode;
            cmd_value_reg    <= item_value;
            cmd_position_reg <= position;
        end
        if (exec_fire)
        begin
            entries_reg    <= entries_next;
            res_value_reg  <= res_value_next;
            res_status_reg <= res_status_next;
            res_length_reg <= ple_pkg::LEN_W'(count_next);
        end
    end

    assign out_valid    = res_valid_reg;
    assign result_value = res_value_reg;
    assign status       = res_status_reg;
    assign length       = res_length_reg;

    // Count never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ple_pkg::CNT_W'(ple_pkg::CAPACITY))
    else $error("entry count above capacity");

    // A full status is only reported with a full list
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_status_reg == ple_pkg::ST_FULL)
        |-> (res_length_reg == ple_pkg::LEN_W'(ple_pkg::CAPACITY)))
    else $error("full status with list not full");

    // A successful push grows the list by one
    assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && cmd_opcode_reg == ple_pkg::OP_PUSH_FRONT
         && res_status_next == ple_pkg::ST_OK)
        |=> (count_reg == $past(count_reg) + ple_pkg::CNT_W'(1)))
    else $error("push did not grow the list");

    // Stall is raised only while a command word waits
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (cmd_valid_reg && res_valid_reg && out_stall))
    else $error("input stalled without a waiting command");

endmodule
